FILE: design/gvbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvbs_pkg: shared types and constants of the grid vertex box smoother
// Controller states, command and status words between controller and
// datapath, divider widths and configuration register indexes.
// ----------------------------------------------------------------------------
package gvbs_pkg;

  localparam int DIV_W  = 46;
  localparam int DVS_W  = 32;
  localparam int SQRT_W = 64;
  localparam int CFG_W  = 7;

  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DRAIN, S_PDIV, S_PWAIT, S_UVDIV, S_UVWAIT,
    S_SQ, S_SUM, S_SQRT, S_SWAIT, S_NDIV, S_NWAIT, S_OUT
  } gvbs_state_t;

  typedef struct packed {
    logic       wr;
    logic       rd_en;
    logic [1:0] dr;
    logic [1:0] dc;
    logic       start_pdiv;
    logic       start_uv;
    logic       start_ndiv;
    logic       cap_pos;
    logic       cap_uv;
    logic       cap_nrm;
    logic       sq;
    logic       sum;
    logic       start_sqrt;
    logic       load_out;
  } gvbs_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic sqrt_done;
  } gvbs_status_t;

endpackage

FILE: design/gvbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvbs_div: serial restoring divider
// One quotient bit per cycle; done pulses after the last quotient bit.
// ----------------------------------------------------------------------------
module gvbs_div #(
  parameter int DW = 46,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quot,
  output logic          done
);

  localparam int CNW = $clog2(DW);

  logic [VW-1:0]  rem;
  logic [VW-1:0]  dvs;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic [VW:0]    trial;

  assign trial = {rem, quot[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem  <= VW'(trial - {1'b0, dvs});
          quot <= {quot[DW-2:0], 1'b1};
        end else begin
          rem  <= trial[VW-1:0];
          quot <= {quot[DW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/gvbs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvbs_sqrt: serial integer square root
// Two radicand bits per cycle; done pulses after the last pair of radicand bits.
// ----------------------------------------------------------------------------
module gvbs_sqrt #(
  parameter int NW = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   radicand,
  output logic [NW/2-1:0] root,
  output logic            done
);

  logic [NW-1:0] n;
  logic [NW-1:0] r;
  logic [NW-1:0] b;
  logic [NW-1:0] trial;
  logic          busy;

  assign trial = r + b;
  assign root  = r[NW/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n    <= radicand;
        r    <= '0;
        b    <= NW'(1) << (NW - 2);
        busy <= 1'b1;
      end else if (busy) begin
        if (n >= trial) begin
          n <= n - trial;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b <= b >> 2;
        if (b == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/gvbs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvbs_datapath: line stores, raster counters, sums and arithmetic
// Holds the three-row line stores, the 3x3 accumulators, the shared
// dividers, the square root unit and the result register.
// ----------------------------------------------------------------------------
module gvbs_datapath
  import gvbs_pkg::*;
#(
  parameter int MAX_CELLS = 64,
  parameter int POS_WIDTH = 24,
  parameter int NRM_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        write_enable,
  input  logic                        write_index,
  input  logic [CFG_W-1:0]            write_data,
  input  gvbs_cmd_t                   cmd,
  output gvbs_status_t                status,
  input  logic signed [POS_WIDTH-1:0] in_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_pos_y,
  input  logic signed [POS_WIDTH-1:0] in_pos_z,
  input  logic signed [NRM_WIDTH-1:0] in_nrm_x,
  input  logic signed [NRM_WIDTH-1:0] in_nrm_y,
  input  logic signed [NRM_WIDTH-1:0] in_nrm_z,
  output logic signed [POS_WIDTH-1:0] avg_pos_x,
  output logic signed [POS_WIDTH-1:0] avg_pos_y,
  output logic signed [POS_WIDTH-1:0] avg_pos_z,
  output logic signed [NRM_WIDTH-1:0] unit_nrm_x,
  output logic signed [NRM_WIDTH-1:0] unit_nrm_y,
  output logic signed [NRM_WIDTH-1:0] unit_nrm_z,
  output logic signed [NRM_WIDTH-1:0] slope_value,
  output logic [15:0]                 u_coord,
  output logic [15:0]                 v_coord,
  output logic                        last_out
);

  localparam int CW    = $clog2(MAX_CELLS + 4);
  localparam int LINE  = MAX_CELLS + 3;
  localparam int DEPTH = 3 * LINE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PSW   = POS_WIDTH + 4;
  localparam int NSW   = NRM_WIDTH + 4;
  localparam int SQW   = 2 * NSW;
  localparam int QW    = SQW + 2;
  localparam int SH2   = 42 - NRM_WIDTH;
  localparam int K2    = 2 * (28 - NRM_WIDTH);
  localparam logic [PSW-1:0] M9 = PSW'(((64'd1 << (PSW + 3)) + 64'd8) / 64'd9);

  // configuration
  logic [CFG_W-1:0] grid_cols;
  logic [CFG_W-1:0] grid_rows;
  logic [CW-1:0]    cols;
  logic [CW-1:0]    rows;
  logic [CW-1:0]    w;
  logic [CW-1:0]    h;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= CFG_W'(1);
      grid_rows <= CFG_W'(1);
    end else if (write_enable) begin
      unique case (write_index)
        REG_GRID_COLS: grid_cols <= write_data;
        REG_GRID_ROWS: grid_rows <= write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_cols == '0) cols = CW'(1);
    else if (int'(grid_cols) > MAX_CELLS) cols = CW'(MAX_CELLS);
    else cols = CW'(grid_cols);
    if (grid_rows == '0) rows = CW'(1);
    else if (int'(grid_rows) > MAX_CELLS) rows = CW'(MAX_CELLS);
    else rows = CW'(grid_rows);
    w = cols + CW'(3);
    h = rows + CW'(3);
  end

  // raster counters
  logic [CW-1:0] column_counter;
  logic [CW-1:0] row_counter;
  logic [1:0]    row_slot;
  logic [CW-1:0] c0, r0, col_next, row_next;
  logic [1:0]    s0, slot_next;

  always_comb begin
    c0 = column_counter;
    r0 = row_counter;
    s0 = row_slot;
    if (column_counter >= w) begin
      c0 = '0;
      r0 = row_counter + 1'b1;
      s0 = (row_slot == 2'd2) ? 2'd0 : row_slot + 2'd1;
    end
    if (r0 >= h) begin
      r0 = '0;
      s0 = 2'd0;
    end
    col_next  = c0 + 1'b1;
    row_next  = r0;
    slot_next = s0;
    if (col_next >= w) begin
      col_next  = '0;
      row_next  = r0 + 1'b1;
      slot_next = (s0 == 2'd2) ? 2'd0 : s0 + 2'd1;
      if (row_next >= h) begin
        row_next  = '0;
        slot_next = 2'd0;
      end
    end
  end

  assign status.emit = (c0 >= CW'(2)) && (r0 >= CW'(2));

  logic [CW-1:0] cur_c;
  logic [CW-1:0] cur_r;
  logic [1:0]    cur_s;
  logic          cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      row_slot       <= 2'd0;
    end else if (cmd.wr) begin
      column_counter <= col_next;
      row_counter    <= row_next;
      row_slot       <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      cur_c    <= c0;
      cur_r    <= r0;
      cur_s    <= s0;
      cur_last <= (c0 == w - 1'b1) && (r0 == h - 1'b1);
    end
  end

  // line stores
  logic [3*POS_WIDTH-1:0] position_line_store [DEPTH];
  logic [3*NRM_WIDTH-1:0] normal_line_store [DEPTH];
  logic [3*POS_WIDTH-1:0] pos_rd;
  logic [3*NRM_WIDTH-1:0] nrm_rd;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic [1:0]             rd_slot;
  logic                   acc_en;

  assign wr_addr = AW'(32'(s0) * LINE + 32'(c0));
  assign rd_slot = (cur_s >= cmd.dr) ? cur_s - cmd.dr : cur_s + 2'd3 - cmd.dr;
  assign rd_addr = AW'(32'(rd_slot) * LINE + 32'(cur_c - CW'(cmd.dc)));

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      position_line_store[wr_addr] <= {in_pos_x, in_pos_y, in_pos_z};
      normal_line_store[wr_addr]   <= {in_nrm_x, in_nrm_y, in_nrm_z};
    end
    if (cmd.rd_en) begin
      pos_rd <= position_line_store[rd_addr];
      nrm_rd <= normal_line_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) acc_en <= 1'b0;
    else acc_en <= cmd.rd_en;
  end

  // 3x3 sums
  logic signed [PSW-1:0] ps [3];
  logic signed [NSW-1:0] ns [3];
  logic [PSW-1:0]        ps_abs [3];
  logic [NSW-1:0]        ns_abs [3];
  logic [POS_WIDTH-1:0]  pw [3];
  logic [NRM_WIDTH-1:0]  nw [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pw[k]     = pos_rd[(2-k)*POS_WIDTH +: POS_WIDTH];
      nw[k]     = nrm_rd[(2-k)*NRM_WIDTH +: NRM_WIDTH];
      ps_abs[k] = ps[k][PSW-1] ? PSW'(-ps[k]) : PSW'(ps[k]);
      ns_abs[k] = ns[k][NSW-1] ? NSW'(-ns[k]) : NSW'(ns[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.wr) begin
        ps[k] <= '0;
        ns[k] <= '0;
      end else if (acc_en) begin
        ps[k] <= ps[k] + {{4{pw[k][POS_WIDTH-1]}}, pw[k]};
        ns[k] <= ns[k] + {{4{nw[k][NRM_WIDTH-1]}}, nw[k]};
      end
    end
  end

  // mean by reciprocal multiply
  logic [2*PSW-1:0] pq [3];
  logic [PSW-4:0]   pmean [3];

  always_ff @(posedge clk) begin
    if (cmd.start_pdiv) begin
      for (int k = 0; k < 3; k++)
        pq[k] <= (2*PSW)'(ps_abs[k] + PSW'(4)) * (2*PSW)'(M9);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) pmean[k] = pq[k][2*PSW-1:PSW+3];
  end

  // squared length
  logic signed [SQW-1:0] sq [3];
  logic [QW-1:0]         qs;
  logic [SQRT_W-1:0]     q_scaled;
  logic                  q_zero;
  logic [SQRT_W/2-1:0]   len;

  assign qs = QW'(unsigned'(sq[0])) + QW'(unsigned'(sq[1])) + QW'(unsigned'(sq[2]));

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      for (int k = 0; k < 3; k++) sq[k] <= ns[k] * ns[k];
    end
    if (cmd.sum) begin
      q_scaled <= SQRT_W'(qs) << K2;
      q_zero   <= (qs == '0);
    end
  end

  gvbs_sqrt #(.NW(SQRT_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_sqrt),
    .radicand (q_scaled),
    .root     (len),
    .done     (status.sqrt_done)
  );

  // shared dividers
  logic [DIV_W-1:0] dvd [3];
  logic [DVS_W-1:0] dvs [3];
  logic [DIV_W-1:0] quo [3];
  logic             dv_done [3];
  logic             dv_start;

  assign dv_start = cmd.start_uv | cmd.start_ndiv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dvd[k] = (DIV_W'(ns_abs[k]) << SH2) + DIV_W'(len >> 1);
      dvs[k] = DVS_W'(len);
    end
    if (cmd.start_uv) begin
      dvd[0] = DIV_W'(cur_c - CW'(2)) << 16;
      dvs[0] = DVS_W'(cols) + DVS_W'(1);
      dvd[1] = DIV_W'(cur_r - CW'(2)) << 16;
      dvs[1] = DVS_W'(rows) + DVS_W'(1);
      dvd[2] = '0;
      dvs[2] = DVS_W'(1);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    gvbs_div #(.DW(DIV_W), .VW(DVS_W)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (dv_start),
      .dividend (dvd[g]),
      .divisor  (dvs[g]),
      .quot     (quo[g]),
      .done     (dv_done[g])
    );
  end

  assign status.div_done = dv_done[0] & dv_done[1] & dv_done[2];

  // results
  logic [POS_WIDTH-1:0] avg [3];
  logic [NRM_WIDTH-1:0] unit [3];
  logic [15:0]          u_res;
  logic [15:0]          v_res;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.cap_pos) begin
        avg[k] <= ps[k][PSW-1] ? POS_WIDTH'(-pmean[k]) : POS_WIDTH'(pmean[k]);
      end
      if (cmd.cap_nrm) begin
        if (q_zero) unit[k] <= '0;
        else unit[k] <= ns[k][NSW-1] ? NRM_WIDTH'(~quo[k] + 1'b1) : NRM_WIDTH'(quo[k]);
      end
    end
    if (cmd.cap_uv) begin
      u_res <= quo[0][15:0];
      v_res <= quo[1][15:0];
    end
    if (cmd.load_out) begin
      avg_pos_x   <= avg[0];
      avg_pos_y   <= avg[1];
      avg_pos_z   <= avg[2];
      unit_nrm_x  <= unit[0];
      unit_nrm_y  <= unit[1];
      unit_nrm_z  <= unit[2];
      slope_value <= unit[1];
      u_coord     <= u_res;
      v_coord     <= v_res;
      last_out    <= cur_last;
    end
  end

endmodule

FILE: design/gvbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvbs_ctrl: sequencing controller
// Steps one vertex through store, window read, divide, root and output.
// ----------------------------------------------------------------------------
module gvbs_ctrl
  import gvbs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  gvbs_status_t status,
  output gvbs_cmd_t    cmd
);

  gvbs_state_t state, state_next;
  logic [1:0]  dr, dr_next;
  logic [1:0]  dc, dc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dr        <= 2'd0;
      dc        <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      dr    <= dr_next;
      dc    <= dc_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    dr_next    = dr;
    dc_next    = dc;
    cmd        = '0;
    cmd.dr     = dr;
    cmd.dc     = dc;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.wr   = in_valid;
        dr_next  = 2'd0;
        dc_next  = 2'd0;
        if (in_valid && status.emit) state_next = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (dc == 2'd2) begin
          dc_next = 2'd0;
          dr_next = dr + 2'd1;
          if (dr == 2'd2) state_next = S_DRAIN;
        end else begin
          dc_next = dc + 2'd1;
        end
      end
      S_DRAIN: state_next = S_PDIV;
      S_PDIV: begin
        cmd.start_pdiv = 1'b1;
        state_next     = S_PWAIT;
      end
      S_PWAIT: begin
        cmd.cap_pos = 1'b1;
        state_next  = S_UVDIV;
      end
      S_UVDIV: begin
        cmd.start_uv = 1'b1;
        state_next   = S_UVWAIT;
      end
      S_UVWAIT: begin
        if (status.div_done) begin
          cmd.cap_uv = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.start_sqrt = 1'b1;
        state_next     = S_SWAIT;
      end
      S_SWAIT: begin
        if (status.sqrt_done) state_next = S_NDIV;
      end
      S_NDIV: begin
        cmd.start_ndiv = 1'b1;
        state_next     = S_NWAIT;
      end
      S_NWAIT: begin
        if (status.div_done) begin
          cmd.cap_nrm = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/grid_vertex_box_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_vertex_box_smoother: 3x3 box filter over a streamed vertex raster
// Mean position, unit summed normal, slope and u,v for every interior vertex.
//
//   channel  handshake               words
//   in       in_valid / in_ready     in_pos_*, in_nrm_*
//   out      out_valid / out_ready   avg_pos_*, unit_nrm_*, slope, u, v, last
//   config   write_enable            write_index, write_data
//
// A vertex with no result is only stored. A vertex with a result is followed,
// before the next one is accepted, by nine line-store reads, a reciprocal
// multiply for the mean, two passes of the serial dividers and a serial
// square root. The next vertex is taken while a result waits on out_ready;
// a second result holds until the first is taken.
// Synchronous reset clears the counters and sets the sizes to 1; the line stores
// are not cleared.
// ----------------------------------------------------------------------------
module grid_vertex_box_smoother
  import gvbs_pkg::*;
#(
  parameter int MAX_CELLS = 64,
  parameter int POS_WIDTH = 24,
  parameter int NRM_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        write_enable,
  input  logic                        write_index,
  input  logic [CFG_W-1:0]            write_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [POS_WIDTH-1:0] in_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_pos_y,
  input  logic signed [POS_WIDTH-1:0] in_pos_z,
  input  logic signed [NRM_WIDTH-1:0] in_nrm_x,
  input  logic signed [NRM_WIDTH-1:0] in_nrm_y,
  input  logic signed [NRM_WIDTH-1:0] in_nrm_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [POS_WIDTH-1:0] avg_pos_x,
  output logic signed [POS_WIDTH-1:0] avg_pos_y,
  output logic signed [POS_WIDTH-1:0] avg_pos_z,
  output logic signed [NRM_WIDTH-1:0] unit_nrm_x,
  output logic signed [NRM_WIDTH-1:0] unit_nrm_y,
  output logic signed [NRM_WIDTH-1:0] unit_nrm_z,
  output logic signed [NRM_WIDTH-1:0] slope_value,
  output logic [15:0]                 u_coord,
  output logic [15:0]                 v_coord,
  output logic                        last_out
);

  gvbs_cmd_t    cmd;
  gvbs_status_t status;

  gvbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gvbs_datapath #(
    .MAX_CELLS (MAX_CELLS),
    .POS_WIDTH (POS_WIDTH),
    .NRM_WIDTH (NRM_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cmd          (cmd),
    .status       (status),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_nrm_x     (in_nrm_x),
    .in_nrm_y     (in_nrm_y),
    .in_nrm_z     (in_nrm_z),
    .avg_pos_x    (avg_pos_x),
    .avg_pos_y    (avg_pos_y),
    .avg_pos_z    (avg_pos_z),
    .unit_nrm_x   (unit_nrm_x),
    .unit_nrm_y   (unit_nrm_y),
    .unit_nrm_z   (unit_nrm_z),
    .slope_value  (slope_value),
    .u_coord      (u_coord),
    .v_coord      (v_coord),
    .last_out     (last_out)
  );

endmodule

FILE: tb/sv/grid_vertex_box_smoother_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_vertex_box_smoother_test: self-checking bench for the box smoother
// Streams whole vertex chunks at several grid sizes, predicts every smoothed
// vertex in a scoreboard and compares each output word field by field, with
// random idling on the input and random and long back-pressure on the output.
// ----------------------------------------------------------------------------
module grid_vertex_box_smoother_test;
  import gvbs_pkg::*;

  localparam int LINE = 67;

  typedef struct packed {
    logic signed [23:0] px, py, pz;
    logic signed [15:0] nx, ny, nz, slope;
    logic [15:0]        u, v;
    logic               last;
  } smooth_word_t;

  class smooth_board;
    longint       pos_line[3][LINE][3];
    longint       nrm_line[3][LINE][3];
    int           col_at, row_at;
    logic [6:0]   cols_reg, rows_reg;
    smooth_word_t pending[$];
    int           errors, checked, mismatches;

    function new();
      col_at = 0; row_at = 0; cols_reg = 1; rows_reg = 1;
      errors = 0; checked = 0; mismatches = 0;
    endfunction

    function int clamp(logic [6:0] v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return int'(v);
    endfunction

    function longint unsigned int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    function longint round_div(longint num, longint unsigned den);
      longint unsigned a, q;
      a = (num < 0) ? -num : num;
      q = (a + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void note_vertex(logic signed [23:0] px, py, pz,
                              logic signed [15:0] nx, ny, nz);
      int cols, rows, w, h, c, r, s, dr, dc, k;
      longint ps[3], ns[3];
      longint unsigned q, len;
      smooth_word_t e;
      cols = clamp(cols_reg); rows = clamp(rows_reg);
      w = cols + 3; h = rows + 3;
      if (col_at >= w) begin
        col_at = 0; row_at++;
      end
      if (row_at >= h) row_at = 0;
      c = col_at; r = row_at;
      pos_line[r % 3][c][0] = longint'(px); pos_line[r % 3][c][1] = longint'(py);
      pos_line[r % 3][c][2] = longint'(pz);
      nrm_line[r % 3][c][0] = longint'(nx); nrm_line[r % 3][c][1] = longint'(ny);
      nrm_line[r % 3][c][2] = longint'(nz);
      col_at = c + 1;
      if (col_at >= w) begin
        col_at = 0;
        row_at = r + 1;
        if (row_at >= h) row_at = 0;
      end
      if (c < 2 || r < 2) return;
      for (k = 0; k < 3; k++) begin
        ps[k] = 0; ns[k] = 0;
      end
      for (dr = 0; dr < 3; dr++) begin
        s = (r - dr) % 3;
        for (dc = 0; dc < 3; dc++)
          for (k = 0; k < 3; k++) begin
            ps[k] += pos_line[s][c - dc][k];
            ns[k] += nrm_line[s][c - dc][k];
          end
      end
      e.px = 24'(round_div(ps[0], 9));
      e.py = 24'(round_div(ps[1], 9));
      e.pz = 24'(round_div(ps[2], 9));
      q = ns[0] * ns[0] + ns[1] * ns[1] + ns[2] * ns[2];
      if (q == 0) begin
        e.nx = 0; e.ny = 0; e.nz = 0;
      end else begin
        len = int_root(q << 24);
        e.nx = 16'(round_div(ns[0] <<< 26, len));
        e.ny = 16'(round_div(ns[1] <<< 26, len));
        e.nz = 16'(round_div(ns[2] <<< 26, len));
      end
      e.slope = e.ny;
      e.u = 16'((longint'(c - 2) << 16) / (cols + 1));
      e.v = 16'((longint'(r - 2) << 16) / (rows + 1));
      e.last = (c == w - 1 && r == h - 1);
      pending = {pending, e};
    endfunction

    function void check_word(smooth_word_t a);
      smooth_word_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected output word %h", a);
        return;
      end
      e = pending.pop_front();
      if (a.px !== e.px || a.py !== e.py || a.pz !== e.pz || a.nx !== e.nx ||
          a.ny !== e.ny || a.nz !== e.nz || a.slope !== e.slope ||
          a.u !== e.u || a.v !== e.v || a.last !== e.last) begin
        errors++;
        if (mismatches++ < 10) begin
          $display("word %0d mismatch: pos exp %0d %0d %0d got %0d %0d %0d",
                   checked, e.px, e.py, e.pz, a.px, a.py, a.pz);
          $display("  nrm exp %0d %0d %0d slope %0d got %0d %0d %0d slope %0d",
                   e.nx, e.ny, e.nz, e.slope, a.nx, a.ny, a.nz, a.slope);
          $display("  uv exp %0d %0d last %0d got %0d %0d last %0d",
                   e.u, e.v, e.last, a.u, a.v, a.last);
        end
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic write_enable = 0, write_index = 0;
  logic [CFG_W-1:0] write_data = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [23:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic signed [15:0] in_nrm_x = 0, in_nrm_y = 0, in_nrm_z = 0;
  logic signed [23:0] avg_pos_x, avg_pos_y, avg_pos_z;
  logic signed [15:0] unit_nrm_x, unit_nrm_y, unit_nrm_z, slope_value;
  logic [15:0] u_coord, v_coord;
  logic last_out;

  smooth_board board = new();
  bit quiet = 0, hold_req = 0;
  int vertices = 0, chunks = 0;

  grid_vertex_box_smoother dut (.*);

  always #10 clk = ~clk;

  initial begin
    #80_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_word({avg_pos_x, avg_pos_y, avg_pos_z, unit_nrm_x, unit_nrm_y,
                        unit_nrm_z, slope_value, u_coord, v_coord, last_out});
  end

  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req && in_valid) begin
        out_ready <= 0;
        for (n = 0; n < 3000; n++) @(posedge clk);
        hold_req = 0;
        out_ready <= 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  task automatic write_reg(logic idx, logic [6:0] val);
    @(posedge clk);
    write_enable <= 1; write_index <= idx; write_data <= val;
    @(posedge clk);
    write_enable <= 0;
    if (idx == REG_GRID_COLS) board.cols_reg = val;
    else board.rows_reg = val;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_nrm(int mode);
    if (mode == 1) return ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384);
    if (mode == 2) return 0;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [23:0] pick_pos(int mode);
    if (mode == 1) return ($urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000);
    return 24'($urandom);
  endfunction

  // mode 0 random, 1 extreme positions with +/-16384 normals, 2 zero normals
  task automatic send_chunk(logic [6:0] cw, logic [6:0] rh, int mode);
    int total, i;
    drain();
    write_reg(REG_GRID_COLS, cw);
    write_reg(REG_GRID_ROWS, rh);
    total = (board.clamp(cw) + 3) * (board.clamp(rh) + 3);
    chunks++;
    @(posedge clk);
    for (i = 0; i < total; i++) begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_valid <= 1;
      in_pos_x <= pick_pos(mode); in_pos_y <= pick_pos(mode);
      in_pos_z <= pick_pos(mode);
      in_nrm_x <= pick_nrm(mode); in_nrm_y <= pick_nrm(mode);
      in_nrm_z <= pick_nrm(mode);
      do @(posedge clk); while (!in_ready);
      board.note_vertex(in_pos_x, in_pos_y, in_pos_z, in_nrm_x, in_nrm_y, in_nrm_z);
      vertices++;
    end
    in_valid <= 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    send_chunk(1, 1, 1);
    send_chunk(1, 1, 2);
    send_chunk(127, 0, 0);
    hold_req = 1;
    send_chunk(3, 2, 0);
    send_chunk(0, 64, 0);
    send_chunk(2, 3, 1);
    while (vertices < 1200) begin
      if (vertices > 1000) quiet = 1;
      if ($urandom_range(0, 7) == 0)
        send_chunk($urandom_range(1, 20), $urandom_range(1, 4), 0);
      else
        send_chunk($urandom_range(1, 6), $urandom_range(1, 6), 0);
    end
    drain();
    $display("Covered %0d vertices in %0d chunks, %0d smoothed words checked,",
             vertices, chunks, board.checked);
    $display("sizes from 1x1 to 64 wide and 64 deep, with clamped size registers.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
